/* src/q2e_pkg.sv */
// Shared types, constants and helpers for the quaternion to Euler angle block.
package q2e_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TERM_W        = 36;
  localparam int ACC_W         = 33;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } quat_item_t;

  typedef struct packed {
    logic signed [15:0] angle_phi;
    logic signed [15:0] angle_theta;
    logic signed [15:0] angle_psi;
  } euler_item_t;

  typedef enum logic [2:0] {
    ORD_XZY = 3'd0,
    ORD_XYZ = 3'd1,
    ORD_YXZ = 3'd2,
    ORD_YZX = 3'd3,
    ORD_ZYX = 3'd4,
    ORD_ZXY = 3'd5,
    ORD_RSV6 = 3'd6,
    ORD_RSV7 = 3'd7
  } rot_order_t;

  // One CORDIC lane: operands, accumulated angle, and a zero-vector flag.
  typedef struct packed {
    logic signed [TERM_W-1:0] x;
    logic signed [TERM_W-1:0] y;
    logic signed [ACC_W-1:0]  acc;
    logic                     zero;
  } lane_t;

  localparam logic signed [ACC_W-1:0] PI_ANGLE = ACC_W'(64'sd1073741824);

  // Arctangent table, 2^30 = pi.
  function automatic logic signed [ACC_W-1:0] atan_entry(input logic [4:0] i);
    logic signed [ACC_W-1:0] r;
    begin
      unique case (i)
        5'd0:  r = ACC_W'(268435456);
        5'd1:  r = ACC_W'(158466703);
        5'd2:  r = ACC_W'(83729454);
        5'd3:  r = ACC_W'(42502378);
        5'd4:  r = ACC_W'(21333665);
        5'd5:  r = ACC_W'(10677233);
        5'd6:  r = ACC_W'(5339919);
        5'd7:  r = ACC_W'(2670123);
        5'd8:  r = ACC_W'(1335082);
        5'd9:  r = ACC_W'(667543);
        5'd10: r = ACC_W'(333772);
        5'd11: r = ACC_W'(166886);
        5'd12: r = ACC_W'(83443);
        5'd13: r = ACC_W'(41722);
        5'd14: r = ACC_W'(20861);
        5'd15: r = ACC_W'(10430);
        5'd16: r = ACC_W'(5215);
        5'd17: r = ACC_W'(2608);
        5'd18: r = ACC_W'(1304);
        5'd19: r = ACC_W'(652);
        5'd20: r = ACC_W'(326);
        5'd21: r = ACC_W'(163);
        5'd22: r = ACC_W'(81);
        5'd23: r = ACC_W'(41);
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  // Pre-rotate into the right half plane, flag the zero vector.
  function automatic lane_t lane_init(input logic signed [TERM_W-1:0] y,
                                      input logic signed [TERM_W-1:0] x);
    lane_t l;
    begin
      l.zero = (x == '0) && (y == '0);
      l.acc  = '0;
      l.x    = x;
      l.y    = y;
      if (x < 0) begin
        l.acc = (y >= 0) ? PI_ANGLE : -PI_ANGLE;
        l.x   = -x;
        l.y   = -y;
      end
      return l;
    end
  endfunction

endpackage

/* src/q2e_cordic_cell.sv */
// One vectoring CORDIC cell: three lanes, one micro-rotation, one register.
module q2e_cordic_cell import q2e_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [4:0]  stage,
  input  logic        vld_in,
  input  lane_t [2:0] lane_in,
  input  logic signed [15:0] aux_in,
  output logic        vld_out,
  output lane_t [2:0] lane_out,
  output logic signed [15:0] aux_out
);

  lane_t [2:0] lane_r, lane_nxt;
  logic        vld_r;
  logic signed [15:0] aux_r;

  // Rotate each lane toward the x axis
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lane_nxt[k] = lane_in[k];
      if (lane_in[k].y >= 0) begin
        lane_nxt[k].x   = lane_in[k].x + (lane_in[k].y >>> stage);
        lane_nxt[k].y   = lane_in[k].y - (lane_in[k].x >>> stage);
        lane_nxt[k].acc = lane_in[k].acc + atan_entry(stage);
      end else begin
        lane_nxt[k].x   = lane_in[k].x - (lane_in[k].y >>> stage);
        lane_nxt[k].y   = lane_in[k].y + (lane_in[k].x >>> stage);
        lane_nxt[k].acc = lane_in[k].acc - atan_entry(stage);
      end
    end
  end

  // Advance the item valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
    aux_r  <= aux_in;
  end

  assign vld_out  = vld_r;
  assign lane_out = lane_r;
  assign aux_out  = aux_r;

endmodule

/* src/q2e_sqrt_cell.sv */
// One restoring square-root cell: settles one result bit per cycle.
module q2e_sqrt_cell import q2e_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [4:0]  step,
  input  logic        vld_in,
  input  logic [57:0] rem_in,
  input  logic [29:0] root_in,
  input  logic signed [TERM_W-1:0] t_in,
  input  lane_t [1:0] lane_in,
  input  logic        neg_in,
  output logic        vld_out,
  output logic [57:0] rem_out,
  output logic [29:0] root_out,
  output logic signed [TERM_W-1:0] t_out,
  output lane_t [1:0] lane_out,
  output logic        neg_out
);

  logic [57:0] rem_r, rem_nxt, trial;
  logic [29:0] root_r, root_nxt;
  logic [5:0]  sh;
  logic        vld_r, neg_r;
  logic signed [TERM_W-1:0] t_r;
  lane_t [1:0] lane_r;

  // Try the next bit of the root
  always_comb begin
    sh      = 6'(2 * (28 - int'(step)));
    trial   = ({28'd0, root_in} << (6'd29 - step)) + (58'd1 << sh);
    rem_nxt = rem_in;
    root_nxt = root_in;
    if (rem_in >= trial) begin
      rem_nxt  = rem_in - trial;
      root_nxt = root_in | (30'd1 << (5'd28 - step));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    t_r    <= t_in;
    lane_r <= lane_in;
    neg_r  <= neg_in;
  end

  assign vld_out  = vld_r;
  assign rem_out  = rem_r;
  assign root_out = root_r;
  assign t_out    = t_r;
  assign lane_out = lane_r;
  assign neg_out  = neg_r;

endmodule

/* src/quaternion_to_euler_angles.sv */
// Top level: quaternion to Euler angles, pipelined square root and CORDIC cells.
//
//  channel | ports                      | handshake
//  --------+----------------------------+-------------------------------
//  input   | in_item                    | start high, busy low
//  result  | out_item                   | out_strobe, one cycle, no stall
//  config  | cfg_we, cfg_order          | write at cfg_we
//
// One item a cycle; the path runs through the product and matrix registers, the
// chain of 29 square-root cells (one root bit each), the CORDIC cells, and the output register.
// busy is always low. Reset clears the valid chain and sets order to XYZ.
// The receiver cannot stall; results leave in input order.
module quaternion_to_euler_angles import q2e_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  quat_item_t  in_item,
  output logic        out_strobe,
  output euler_item_t out_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_order
);

  localparam int SQ_STEPS = 29;

  rot_order_t order_r;
  logic       v0_r, v1_r;
  logic signed [31:0] p_r [10];
  logic signed [TERM_W-1:0] m11, m22, m33, m12, m13, m21, m23, m31, m32;
  logic signed [TERM_W-1:0] ay, ax, by, bx, t, tc;
  logic [TERM_W-1:0] mag;
  logic [57:0] tsq;
  logic        neg;
  lane_t [1:0] lanes_r;
  logic signed [TERM_W-1:0] t_r;
  logic [57:0] rad_r;
  logic        neg_r;
  logic signed [15:0] theta_r, theta_nxt, ph_o, ps_o;
  logic signed [ACC_W-1:0] tmp;

  assign busy = 1'b0;

  // Hold the rotation order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORD_XYZ;
    end else if (cfg_we) begin
      order_r <= rot_order_t'(cfg_order);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= start;
      v1_r <= v0_r;
    end
  end

  // Stage 0: component products
  always_ff @(posedge clk) begin
    p_r[0] <= in_item.quat_w * in_item.quat_w;
    p_r[1] <= in_item.quat_x * in_item.quat_x;
    p_r[2] <= in_item.quat_y * in_item.quat_y;
    p_r[3] <= in_item.quat_z * in_item.quat_z;
    p_r[4] <= in_item.quat_x * in_item.quat_y;
    p_r[5] <= in_item.quat_w * in_item.quat_z;
    p_r[6] <= in_item.quat_x * in_item.quat_z;
    p_r[7] <= in_item.quat_w * in_item.quat_y;
    p_r[8] <= in_item.quat_y * in_item.quat_z;
    p_r[9] <= in_item.quat_w * in_item.quat_x;
  end

  // Stage 1: matrix terms, order select, asin radicand
  always_comb begin
    m11 = TERM_W'(p_r[0]) + TERM_W'(p_r[1]) - TERM_W'(p_r[2]) - TERM_W'(p_r[3]);
    m22 = TERM_W'(p_r[0]) - TERM_W'(p_r[1]) + TERM_W'(p_r[2]) - TERM_W'(p_r[3]);
    m33 = TERM_W'(p_r[0]) - TERM_W'(p_r[1]) - TERM_W'(p_r[2]) + TERM_W'(p_r[3]);
    m12 = (TERM_W'(p_r[4]) + TERM_W'(p_r[5])) <<< 1;
    m13 = (TERM_W'(p_r[6]) - TERM_W'(p_r[7])) <<< 1;
    m21 = (TERM_W'(p_r[4]) - TERM_W'(p_r[5])) <<< 1;
    m23 = (TERM_W'(p_r[8]) + TERM_W'(p_r[9])) <<< 1;
    m31 = (TERM_W'(p_r[6]) + TERM_W'(p_r[7])) <<< 1;
    m32 = (TERM_W'(p_r[8]) - TERM_W'(p_r[9])) <<< 1;
    unique case (order_r)
      ORD_XZY: begin ay = -m32; ax = m22; t = m12; neg = 1'b0; by = -m13; bx = m11; end
      ORD_YXZ: begin ay = -m13; ax = m33; t = m23; neg = 1'b0; by = -m21; bx = m22; end
      ORD_YZX: begin ay = m31; ax = m11; t = m21; neg = 1'b1; by = m23; bx = m22; end
      ORD_ZYX: begin ay = -m21; ax = m11; t = m31; neg = 1'b0; by = -m32; bx = m33; end
      ORD_ZXY: begin ay = m12; ax = m22; t = m32; neg = 1'b1; by = m31; bx = m33; end
      default: begin ay = m23; ax = m33; t = m13; neg = 1'b1; by = m12; bx = m11; end
    endcase
    tc = t;
    if (t > TERM_W'(64'sd268435456)) tc = TERM_W'(64'sd268435456);
    if (t < -TERM_W'(64'sd268435456)) tc = -TERM_W'(64'sd268435456);
    mag = tc[TERM_W-1] ? TERM_W'(-tc) : TERM_W'(tc);
    tsq = 58'(mag[28:0]) * 58'(mag[28:0]);
  end

  always_ff @(posedge clk) begin
    lanes_r[0] <= lane_init(ay, ax);
    lanes_r[1] <= lane_init(by, bx);
    t_r        <= tc;
    rad_r      <= (58'd1 << 56) - tsq;
    neg_r      <= neg;
  end

  // Square-root chain
  logic [SQ_STEPS:0]        sv;
  logic [57:0]              srem [SQ_STEPS+1];
  logic [29:0]              sroot [SQ_STEPS+1];
  logic signed [TERM_W-1:0] st [SQ_STEPS+1];
  lane_t [1:0]              sl [SQ_STEPS+1];
  logic [SQ_STEPS:0]        sn;

  assign sv[0]    = v1_r;
  assign srem[0]  = rad_r;
  assign sroot[0] = '0;
  assign st[0]    = t_r;
  assign sl[0]    = lanes_r;
  assign sn[0]    = neg_r;

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
    q2e_sqrt_cell u_sq (
      .clk(clk), .rst_n(rst_n), .step(5'(g)),
      .vld_in(sv[g]), .rem_in(srem[g]), .root_in(sroot[g]), .t_in(st[g]),
      .lane_in(sl[g]), .neg_in(sn[g]),
      .vld_out(sv[g+1]), .rem_out(srem[g+1]), .root_out(sroot[g+1]),
      .t_out(st[g+1]), .lane_out(sl[g+1]), .neg_out(sn[g+1])
    );
  end

  // CORDIC chain: lanes phi, psi, theta
  logic [CORDIC_STAGES:0] cv;
  lane_t [2:0]            cl [CORDIC_STAGES+1];
  logic signed [15:0]     ca [CORDIC_STAGES+1];

  assign cv[0]    = sv[SQ_STEPS];
  assign cl[0][0] = sl[SQ_STEPS][0];
  assign cl[0][1] = sl[SQ_STEPS][1];
  assign cl[0][2] = lane_init(st[SQ_STEPS], TERM_W'({1'b0, sroot[SQ_STEPS]}));
  assign ca[0]    = {15'd0, sn[SQ_STEPS]};

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cd
    q2e_cordic_cell u_cd (
      .clk(clk), .rst_n(rst_n), .stage(5'(g)),
      .vld_in(cv[g]), .lane_in(cl[g]), .aux_in(ca[g]),
      .vld_out(cv[g+1]), .lane_out(cl[g+1]), .aux_out(ca[g+1])
    );
  end

  // Round to 16-bit binary angles; theta takes its sign flag and is clamped to +/-16384
  always_comb begin
    lane_t lp, ls, lt;
    lp = cl[CORDIC_STAGES][0];
    ls = cl[CORDIC_STAGES][1];
    lt = cl[CORDIC_STAGES][2];
    tmp  = lp.zero ? '0 : lp.acc;
    ph_o = 16'((tmp + ACC_W'(16384)) >>> 15);
    tmp  = ls.zero ? '0 : ls.acc;
    ps_o = 16'((tmp + ACC_W'(16384)) >>> 15);
    tmp  = lt.zero ? '0 : lt.acc;
    if (ca[CORDIC_STAGES][0]) tmp = -tmp;
    tmp = (tmp + ACC_W'(16384)) >>> 15;
    if (tmp > ACC_W'(16384)) tmp = ACC_W'(16384);
    if (tmp < -ACC_W'(16384)) tmp = -ACC_W'(16384);
    theta_nxt = 16'(tmp);
  end

  logic out_v_r;
  euler_item_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= cv[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    out_r   <= '{angle_phi: ph_o, angle_theta: theta_nxt, angle_psi: ps_o};
    theta_r <= theta_nxt;
  end

  assign out_strobe = out_v_r;
  assign out_item   = out_r;

  // Checks
  a_theta_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.angle_theta <= 16'sd16384 &&
                    out_item.angle_theta >= -16'sd16384))
    else $error("theta out of range");
  a_theta_copy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_item.angle_theta == theta_r)
    else $error("theta register mismatch");
  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

endmodule
